/* hdl/oli_pkg.sv */
// Shared types and codes for the ordered list block.
package oli_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_POS  = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_DEL_POS  = 3'd3,
    OP_DEL_HEAD = 3'd4,
    OP_DEL_TAIL = 3'd5,
    OP_FIND     = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_LOAD  = 2'd1,
    CM_LEFT  = 2'd2,
    CM_RIGHT = 2'd3
  } cell_mode_t;

endpackage

/* hdl/oli_req_if.sv */
// Request channel: one list operation per item.
interface oli_req_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               op;
  logic [4:0]               pos;
  logic signed [31:0]       val;

  modport source (output valid, output op, output pos, output val, input ready);
  modport sink   (input valid, input op, input pos, input val, output ready);
endinterface

/* hdl/oli_rsp_if.sv */
// Response channel: status, found position and entry count per item.
interface oli_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] found_pos;
  logic [4:0] item_count;

  modport source (output valid, output status, output found_pos, output item_count,
                  input ready);
  modport sink   (input valid, input status, input found_pos, input item_count,
                  output ready);
endinterface

/* hdl/oli_cell.sv */
// One list entry: holds a value, shifts with its neighbors, compares to the key.
module oli_cell import oli_pkg::*; (
  input  logic               clk,
  input  cell_mode_t         mode,
  input  logic signed [31:0] val,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  output logic signed [31:0] data,
  output logic               match
);

  always_ff @(posedge clk) begin
    unique case (mode)
      CM_LOAD:  data <= val;
      CM_LEFT:  data <= left;
      CM_RIGHT: data <= right;
      default:  data <= data;
    endcase
  end

  assign match = (data == val);

endmodule

/* hdl/ordered_list_insert_delete_find_top.sv */
// Top level of the ordered list: a row of entry cells plus count and result register.
//
//  channel | dir | fields
//  req     | in  | op[2:0], pos[4:0], val[31:0] signed
//  rsp     | out | status[1:0], found_pos[4:0], item_count[4:0]
//
// One item per cycle while rsp.ready is high: every cell shifts and compares in the cycle
// the item is accepted; the result is valid in the cycle right after the accepting edge.
// Reset clears the count and the result valid; entry contents are never cleared.
// req.ready is low during reset and while a result waits and rsp.ready is low.
module ordered_list_insert_delete_find_top import oli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  oli_req_if.sink   req,
  oli_rsp_if.source rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CW-1:0]      count, count_next;
  logic [XW-1:0]      cnt_x, pos_x;
  logic               acc, full, empty;
  logic               ins, del, dec;
  logic [IW-1:0]      idx;
  status_t            st;
  cell_mode_t         mode [CAPACITY];
  logic signed [31:0] data [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CW-1:0]      found;

  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign cnt_x     = XW'(count);
  assign pos_x     = XW'(req.pos);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    st  = ST_OK;
    ins = 1'b0;
    del = 1'b0;
    dec = 1'b0;
    idx = '0;
    unique case (req.op)
      OP_INS_POS: begin
        if (pos_x == '0 || pos_x > cnt_x + XW'(1)) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else begin
          ins = 1'b1;
          idx = IW'(pos_x - XW'(1));
        end
      end
      OP_INS_HEAD: begin
        if (full) st = ST_FULL;
        else ins = 1'b1;
      end
      OP_INS_TAIL: begin
        if (full) st = ST_FULL;
        else begin
          ins = 1'b1;
          idx = IW'(count);
        end
      end
      OP_DEL_POS: begin
        if (empty) st = ST_EMPTY;
        else if (pos_x == '0 || pos_x > cnt_x) st = ST_RANGE;
        else begin
          del = 1'b1;
          idx = IW'(pos_x - XW'(1));
        end
      end
      OP_DEL_HEAD: begin
        if (empty) st = ST_EMPTY;
        else del = 1'b1;
      end
      OP_DEL_TAIL: begin
        if (empty) st = ST_EMPTY;
        else dec = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ins) count_next = count + CW'(1);
    else if (del || dec) count_next = count - CW'(1);
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      mode[i] = CM_HOLD;
      if (acc && ins) begin
        if (IW'(i) == idx) mode[i] = CM_LOAD;
        else if (IW'(i) > idx) mode[i] = CM_LEFT;
      end else if (acc && del && IW'(i) >= idx) begin
        mode[i] = CM_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = data[g];
    end else begin : g_mid_r
      assign right_d = data[g+1];
    end
    oli_cell u_cell (
      .clk   (clk),
      .mode  (mode[g]),
      .val   (req.val),
      .left  (left_d),
      .right (right_d),
      .data  (data[g]),
      .match (match[g])
    );
  end

  always_comb begin
    found = '0;
    if (req.op == OP_FIND) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (match[k] && CW'(k) < count) found = CW'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (acc) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.status     <= st;
      rsp.found_pos  <= POS_W'(found);
      rsp.item_count <= CNT_W'(count_next);
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    acc && ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_find_only: assert property (@(posedge clk) disable iff (rst)
    acc && req.op != OP_FIND |=> rsp.found_pos == '0)
    else $error("found position on a non-find item");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    acc && st == ST_EMPTY |-> count == '0)
    else $error("empty status with entries present");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    acc && st != ST_OK |=> count == $past(count))
    else $error("rejected item changed the count");

endmodule

/* tb/sv/tb_ordered_list_insert_delete_find_top.sv */
// Ordered list testbench: directed and random operations checked against a local list model.
`timescale 1ns / 100ps

module tb_ordered_list_insert_delete_find_top;
  import oli_pkg::*;

  localparam int LIST_CAP = 16;
  localparam int RAND_OPS = 450;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT = 29;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } list_req_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] found_pos;
    logic [CNT_W-1:0] item_count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  oli_req_if req_ch ();
  oli_rsp_if rsp_ch ();

  ordered_list_insert_delete_find_top #(.CAPACITY(LIST_CAP)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_req_t pending_ops[$];
  list_rsp_t predicted_rsp[$];

  logic signed [VAL_W-1:0] list_vals[LIST_CAP];
  int list_len = 0;
  int gen_len = 0;
  int total_ops = 0;
  int sent_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int err_cnt = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int found_hits = 0;
  logic req_fire = 1'b0;
  logic no_gaps;

  assign no_gaps = (sent_cnt >= 200) && (sent_cnt < 300);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic list_rsp_t list_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                           logic signed [VAL_W-1:0] val);
    list_rsp_t r;
    int idx;
    int k;
    r.status = ST_OK;
    r.found_pos = '0;
    idx = -1;
    case (op)
      OP_INS_POS, OP_INS_HEAD, OP_INS_TAIL: begin
        if (op == OP_INS_POS && (pos < 1 || pos > list_len + 1)) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          idx = (op == OP_INS_POS) ? pos - 1 : (op == OP_INS_HEAD) ? 0 : list_len;
          for (k = list_len; k > idx; k--) list_vals[k] = list_vals[k-1];
          list_vals[idx] = val;
          list_len++;
        end
      end
      OP_DEL_POS, OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_DEL_POS && (pos < 1 || pos > list_len)) begin
          r.status = ST_RANGE;
        end else begin
          idx = (op == OP_DEL_POS) ? pos - 1 : (op == OP_DEL_HEAD) ? 0 : list_len - 1;
          for (k = idx; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
          list_len--;
        end
      end
      OP_FIND: begin
        for (k = 0; k < list_len; k++)
          if (list_vals[k] == val) r.found_pos = POS_W'(k + 1);
      end
      default: ;
    endcase
    r.item_count = CNT_W'(list_len);
    return r;
  endfunction

  // Tracks the count only, so the generator can keep positions mostly legal.
  task automatic add_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                        logic signed [VAL_W-1:0] val);
    list_req_t it;
    it.op = op;
    it.pos = pos;
    it.val = val;
    pending_ops.push_back(it);
    total_ops++;
    case (op)
      OP_INS_POS:
        if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_CAP) gen_len++;
      OP_INS_HEAD, OP_INS_TAIL:
        if (gen_len < LIST_CAP) gen_len++;
      OP_DEL_POS:
        if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      OP_DEL_HEAD, OP_DEL_TAIL:
        if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endtask

  initial begin : stim
    logic signed [VAL_W-1:0] val_pool[6];
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;
    int r;
    bit grow;
    req_ch.valid = 1'b0;
    req_ch.op = '0;
    req_ch.pos = '0;
    req_ch.val = '0;
    rsp_ch.ready = 1'b0;
    val_pool[0] = 32'sh80000000;
    val_pool[1] = 32'sh7fffffff;
    val_pool[2] = -32'sd1;
    val_pool[3] = 32'sd0;
    val_pool[4] = 32'sd5;
    val_pool[5] = 32'sh55aa55aa;

    // empty list, then range checks and extreme values
    add_op(OP_DEL_TAIL, 0, 0);
    add_op(OP_DEL_HEAD, 0, 0);
    add_op(OP_DEL_POS, 0, 0);
    add_op(OP_FIND, 0, 0);
    add_op(OP_INS_POS, 0, 1);
    add_op(OP_INS_POS, 2, 1);
    add_op(OP_INS_POS, 1, 32'sh80000000);
    add_op(OP_INS_HEAD, 0, 32'sh7fffffff);
    add_op(OP_INS_TAIL, 0, -32'sd1);
    add_op(OP_INS_POS, 4, 0);
    add_op(OP_INS_POS, 31, 3);
    add_op(OP_FIND, 0, 32'sh80000000);
    add_op(OP_FIND, 0, 32'sh12345678);
    add_op(OP_INS_TAIL, 0, 32'sh7fffffff);
    add_op(OP_FIND, 0, 32'sh7fffffff);
    add_op(OP_UNUSED, 31, -32'sd1);
    add_op(OP_DEL_POS, 0, 0);
    add_op(OP_DEL_POS, 31, 0);
    add_op(OP_DEL_POS, 3, 0);
    while (gen_len < LIST_CAP) add_op(OP_INS_TAIL, 0, $urandom);
    // full list: range check wins over full check
    add_op(OP_INS_POS, 18, 1);
    add_op(OP_INS_POS, 17, 1);
    add_op(OP_INS_HEAD, 0, 1);
    add_op(OP_INS_TAIL, 0, 1);
    add_op(OP_DEL_POS, 16, 0);
    add_op(OP_DEL_HEAD, 0, 0);
    add_op(OP_DEL_TAIL, 0, 0);

    grow = 1'b0;
    repeat (RAND_OPS) begin
      r = $urandom_range(99);
      val = ($urandom_range(99) < 60) ? val_pool[$urandom_range(5)] : $urandom;
      if (r < 6) begin
        op = OP_W'($urandom_range(7));
        pos = POS_W'($urandom_range(31));
      end else if (r < 26) begin
        op = OP_FIND;
        pos = POS_W'($urandom_range(31));
      end else if (r < (grow ? 80 : 40)) begin
        op = OP_W'($urandom_range(OP_INS_TAIL, OP_INS_POS));
        pos = POS_W'((op == OP_INS_POS) ? $urandom_range(gen_len + 1, 1)
                                        : $urandom_range(31));
      end else begin
        op = OP_W'($urandom_range(OP_DEL_TAIL, OP_DEL_POS));
        pos = POS_W'((op == OP_DEL_POS) ? $urandom_range((gen_len > 0) ? gen_len : 1, 1)
                                        : $urandom_range(31));
      end
      add_op(op, pos, val);
      if (gen_len == LIST_CAP && $urandom_range(3) == 0) grow = 1'b0;
      if (gen_len == 0 && $urandom_range(3) == 0) grow = 1'b1;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (accepted_cnt != total_ops || predicted_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d operations, checked %0d results.", accepted_cnt, checked_cnt);
    $display("Full rejects %0d, empty rejects %0d, finds that hit %0d.",
             full_hits, empty_hits, found_hits);
    if (err_cnt == 0) begin
      $display("[ordered_list_insert_delete_find_top] OK");
    end else begin
      $display("[ordered_list_insert_delete_find_top] ERROR");
    end
    $finish;
  end

  always @(negedge clk) begin : drive
    list_req_t nxt;
    if (!rst) begin
      if (!req_ch.valid || req_fire) begin
        if (pending_ops.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_ops.pop_front();
          req_ch.op <= nxt.op;
          req_ch.pos <= nxt.pos;
          req_ch.val <= nxt.val;
          req_ch.valid <= 1'b1;
          sent_cnt++;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : monitor
    list_rsp_t want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        checked_cnt++;
        if (predicted_rsp.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item, actual status %0d found_pos %0d item_count %0d",
                   $time, rsp_ch.status, rsp_ch.found_pos, rsp_ch.item_count);
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp_ch.status !== want.status) begin
            err_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_ch.status);
          end
          if (rsp_ch.found_pos !== want.found_pos) begin
            err_cnt++;
            $display("%0t: found_pos expected %0d actual %0d", $time, want.found_pos,
                     rsp_ch.found_pos);
          end
          if (rsp_ch.item_count !== want.item_count) begin
            err_cnt++;
            $display("%0t: item_count expected %0d actual %0d", $time, want.item_count,
                     rsp_ch.item_count);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        want = list_apply(req_ch.op, req_ch.pos, req_ch.val);
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_EMPTY) empty_hits++;
        if (want.found_pos != 0) found_hits++;
        predicted_rsp.push_back(want);
        accepted_cnt++;
      end
    end
  end

  initial begin : watchdog
    #200000;
    $display("[ordered_list_insert_delete_find_top] ERROR");
    $finish;
  end

endmodule
